FILE: sv/lpb_pkg.sv
// Shared types and constants for the largest_prime_below block.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package lpb_pkg;

    // Default data width of the limit and the result
    localparam int LPB_WIDTH = 16;

    // Smallest limit that has a prime below it
    localparam int LPB_MIN_LIMIT = 3;

    // First trial divisor
    localparam int LPB_FIRST_DIV = 2;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_LOOP  = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // Response of the remainder unit
    typedef struct packed {
        logic done;      // one-cycle pulse, remainder is final
        logic rem_zero;  // remainder is zero, divisor divides evenly
    } t_rem_rsp;

endpackage

`default_nettype wire

FILE: sv/lpb_rem.sv
// Iterative remainder unit: restoring division, one quotient bit per cycle.
// Depends on lpb_pkg (t_rem_rsp).
`timescale 1ns / 1ps
`default_nettype none

module lpb_rem #(
    parameter int WIDTH = lpb_pkg::LPB_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_dividend,
    input  wire logic [WIDTH-1:0] i_divisor,
    output lpb_pkg::t_rem_rsp     o_rsp
);
    import lpb_pkg::*;

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_dvs, n_dvs;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    // Shift in the next dividend bit and try to subtract the divisor
    always_comb begin
        trial = {r_rem, r_quo[WIDTH-1]};
        diff  = trial - {1'b0, r_dvs};
    end

    // Advance one bit per cycle while busy
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
            n_quo = {r_quo[WIDTH-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.rem_zero = (r_rem == '0);

endmodule

`default_nettype wire

FILE: sv/largest_prime_below.sv
// Top level: previous-prime search by trial division around a shared remainder unit.
// Depends on lpb_pkg and lpb_rem.
//
// Usage:
//   Input channel i_valid / o_ready carries i_limit. The block takes one limit
//   at a time; o_ready is high only while the sequencer is idle.
//   Output channel o_valid / i_ready carries o_prime and o_error, one beat per
//   limit. A limit below three gives o_error = 1 and o_prime = 0.
//   Sequence: a limit below three goes straight to the done state. Otherwise
//   each candidate passes a check state, and each trial division a launch
//   step, WIDTH bit steps in the shared remainder unit and a wait for its
//   done flag; a prime above three ends with a closing bound test, and
//   loading the output register ends every search.
//   The result waits in an output register; once it is loaded the block is
//   idle again and takes the next limit even while the receiver stalls. A
//   finished search holds until the output register is free.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   any pending output beat. Nothing is stored between requests.
`timescale 1ns / 1ps
`default_nettype none

module largest_prime_below #(
    parameter int WIDTH = lpb_pkg::LPB_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_limit,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_prime,
    output logic                  o_error
);
    import lpb_pkg::*;

    localparam logic [WIDTH-1:0] MIN_LIMIT = WIDTH'(LPB_MIN_LIMIT);
    localparam logic [WIDTH-1:0] FIRST_DIV = WIDTH'(LPB_FIRST_DIV);
    localparam logic [WIDTH:0]   FIRST_SQ  = (WIDTH+1)'(LPB_FIRST_DIV * LPB_FIRST_DIV);

    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_cand, n_cand;
    logic [WIDTH-1:0] r_div, n_div;
    logic [WIDTH:0]   r_sq, n_sq;
    logic             r_res_err, n_res_err;
    logic             r_o_valid, n_o_valid;
    logic [WIDTH-1:0] r_o_prime, n_o_prime;
    logic             r_o_error, n_o_error;

    logic             rem_start;
    t_rem_rsp         rem_rsp;

    // Shared remainder unit: candidate mod divisor
    lpb_rem #(
        .WIDTH(WIDTH)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_cand),
        .i_divisor  (r_div),
        .o_rsp      (rem_rsp)
    );

    // Sequence candidates and divisors
    always_comb begin
        n_state   = r_state;
        n_cand    = r_cand;
        n_div     = r_div;
        n_sq      = r_sq;
        n_res_err = r_res_err;
        n_o_valid = r_o_valid;
        n_o_prime = r_o_prime;
        n_o_error = r_o_error;
        rem_start = 1'b0;

        // Drop the output beat once taken
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_limit < MIN_LIMIT) begin
                        n_cand    = '0;
                        n_res_err = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        n_cand    = i_limit - 1'b1;
                        n_res_err = 1'b0;
                        n_state   = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                // Two and three are prime without a trial
                if (r_cand <= MIN_LIMIT) begin
                    n_state = S_DONE;
                end else begin
                    n_div   = FIRST_DIV;
                    n_sq    = FIRST_SQ;
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                // Past the square root: no divisor left, candidate is prime
                if (r_sq > {1'b0, r_cand}) begin
                    n_state = S_DONE;
                end else begin
                    rem_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (rem_rsp.done) begin
                    if (rem_rsp.rem_zero) begin
                        n_cand  = r_cand - 1'b1;
                        n_state = S_CHECK;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        n_sq    = r_sq + {r_div, 1'b1};
                        n_div   = r_div + 1'b1;
                        n_state = S_LOOP;
                    end
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_prime = r_cand;
                    n_o_error = r_res_err;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_cand    <= n_cand;
        r_div     <= n_div;
        r_sq      <= n_sq;
        r_res_err <= n_res_err;
        r_o_prime <= n_o_prime;
        r_o_error <= n_o_error;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_o_valid;
    assign o_prime = r_o_prime;
    assign o_error = r_o_error;

endmodule

`default_nettype wire

FILE: sv/lpb_checker.sv
// Port-level assertions for largest_prime_below, attached by bind.
// Depends on lpb_pkg for the default width and the first trial divisor.
`timescale 1ns / 1ps
`default_nettype none

module lpb_checker #(
    parameter int WIDTH = lpb_pkg::LPB_WIDTH
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             o_ready,
    input wire logic             o_valid,
    input wire logic             i_ready,
    input wire logic [WIDTH-1:0] o_prime,
    input wire logic             o_error
);
    import lpb_pkg::*;

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_prime) && $stable(o_error))
        else $error("output beat changed while stalled");

    // Error beat carries prime zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_prime == '0)
        else $error("error beat with nonzero prime");

    // Good beat carries at least two
    a_prime_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_error |-> o_prime >= WIDTH'(LPB_FIRST_DIV))
        else $error("prime below two");

    // One limit at a time: busy right after a limit is accepted
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after accepting a limit");

    // Reset drops any output beat
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind largest_prime_below lpb_checker #(.WIDTH(WIDTH)) u_lpb_checker (.*);

`default_nettype wire
